/* hdl/ccb_pkg.sv */
// Shared types, codes and decode helpers for the character-class bitmap builder.
// No dependencies; used by ccb_step, ccb_word_out and char_class_bitmap_builder.
package ccb_pkg;

    localparam int MAP_BITS  = 256;
    localparam int WORD_BITS = 64;

    localparam logic [7:0] CODE_CARET  = 8'h5E;
    localparam logic [7:0] CODE_DASH   = 8'h2D;
    localparam logic [7:0] CODE_BSLASH = 8'h5C;
    localparam logic [7:0] CODE_X      = 8'h78;
    localparam logic [7:0] CODE_ZERO   = 8'h30;
    localparam logic [7:0] CODE_SEVEN  = 8'h37;
    localparam logic [7:0] CODE_NINE   = 8'h39;
    localparam logic [7:0] CODE_UA     = 8'h41;
    localparam logic [7:0] CODE_UF     = 8'h46;
    localparam logic [7:0] CODE_LA     = 8'h61;
    localparam logic [7:0] CODE_LF     = 8'h66;

    // Named escape letters and their decoded codes.
    localparam logic [7:0] ESC_N = 8'h6E;
    localparam logic [7:0] ESC_A = 8'h61;
    localparam logic [7:0] ESC_B = 8'h62;
    localparam logic [7:0] ESC_E = 8'h65;
    localparam logic [7:0] ESC_F = 8'h66;
    localparam logic [7:0] ESC_R = 8'h72;
    localparam logic [7:0] ESC_T = 8'h74;
    localparam logic [7:0] ESC_V = 8'h76;

    localparam logic [7:0] VAL_NL  = 8'd10;
    localparam logic [7:0] VAL_BEL = 8'd7;
    localparam logic [7:0] VAL_BS  = 8'd8;
    localparam logic [7:0] VAL_ESC = 8'd27;
    localparam logic [7:0] VAL_FF  = 8'd12;
    localparam logic [7:0] VAL_CR  = 8'd13;
    localparam logic [7:0] VAL_TAB = 8'd9;
    localparam logic [7:0] VAL_VT  = 8'd11;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_OCT1,
        PH_OCT2,
        PH_HEX0,
        PH_HEX1
    } esc_phase_t;

    typedef struct packed {
        logic [MAP_BITS-1:0] member_map;
        logic                negate_flag;
        logic                at_start;
        logic [7:0]          prev_code;
        logic                prev_valid;
        logic                dash_pending;
        esc_phase_t          escape_phase;
        logic [8:0]          escape_value;
    } ccb_state_t;

    localparam ccb_state_t STATE_RESET = '{
        member_map:   '0,
        negate_flag:  1'b0,
        at_start:     1'b1,
        prev_code:    8'd0,
        prev_valid:   1'b0,
        dash_pending: 1'b0,
        escape_phase: PH_IDLE,
        escape_value: 9'd0
    };

    function automatic logic is_octal(logic [7:0] b);
        return (b >= CODE_ZERO) && (b <= CODE_SEVEN);
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return ((b >= CODE_ZERO) && (b <= CODE_NINE))
            || ((b >= CODE_UA) && (b <= CODE_UF))
            || ((b >= CODE_LA) && (b <= CODE_LF));
    endfunction

    function automatic logic [3:0] hex_digit(logic [7:0] b);
        logic [7:0] v;
        if (b <= CODE_NINE)
            v = b - CODE_ZERO;
        else if (b <= CODE_UF)
            v = b - CODE_UA + 8'd10;
        else
            v = b - CODE_LA + 8'd10;
        return v[3:0];
    endfunction

    function automatic logic [7:0] named_code(logic [7:0] b);
        logic [7:0] c;
        case (b)
            ESC_N:   c = VAL_NL;
            ESC_A:   c = VAL_BEL;
            ESC_B:   c = VAL_BS;
            ESC_E:   c = VAL_ESC;
            ESC_F:   c = VAL_FF;
            ESC_R:   c = VAL_CR;
            ESC_T:   c = VAL_TAB;
            ESC_V:   c = VAL_VT;
            default: c = b;
        endcase
        return c;
    endfunction

    // Set one code, or close a pending range with a 256-bit compare mask.
    function automatic ccb_state_t deliver(ccb_state_t s, logic [7:0] code);
        ccb_state_t r;
        logic [7:0] lo;
        logic [7:0] hi;
        r = s;
        if (s.dash_pending) begin
            lo = (code < s.prev_code) ? code : s.prev_code;
            hi = (code < s.prev_code) ? s.prev_code : code;
            for (int i = 0; i < MAP_BITS; i++) begin
                if ((8'(i) >= lo) && (8'(i) <= hi))
                    r.member_map[i] = 1'b1;
            end
            r.dash_pending = 1'b0;
            r.prev_valid   = 1'b0;
        end
        else begin
            r.member_map[code] = 1'b1;
            r.prev_code        = code;
            r.prev_valid       = 1'b1;
        end
        return r;
    endfunction

    function automatic ccb_state_t plain_byte(ccb_state_t s, logic [7:0] b, logic is_last);
        ccb_state_t r;
        logic       caret_taken;
        r           = s;
        caret_taken = 1'b0;
        if (r.at_start) begin
            r.at_start = 1'b0;
            if (b == CODE_CARET) begin
                r.negate_flag = 1'b1;
                caret_taken   = 1'b1;
            end
        end
        if (!caret_taken) begin
            if (b == CODE_BSLASH) begin
                r.escape_phase = PH_ESC;
                r.escape_value = 9'd0;
            end
            else if (!r.dash_pending && (b == CODE_DASH) && r.prev_valid && !is_last)
                r.dash_pending = 1'b1;
            else
                r = deliver(r, b);
        end
        return r;
    endfunction

endpackage

/* hdl/char_class_bitmap_builder.sv */
// Top level of the character-class bitmap builder: input register, class state,
// per-byte update (ccb_step) and word serializer (ccb_word_out). Depends on ccb_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, spec_byte, spec_end) carries one spec byte
//   per beat; spec_end marks the last byte of a class. Output channel
//   (out_valid/out_ready, word_index, class_word, final_word) carries the
//   finished 256-bit map as four beats, word 0 first, final_word on word 3.
//   Path: a byte is registered on accept and folded into the class state when
//   it advances out of the input register; for a last byte the map is loaded into
//   the word buffer at that point, and word 0 is offered from that buffer.
//   Throughput: one byte per cycle unless a last byte waits on the buffer. The word
//   buffer sends one word per cycle while out_ready is high; a last byte waits in the
//   input register only while the previous map still drains.
//   Reset: clears the class state (empty map, no negation, at start), the
//   input register and the word buffer; no output beats are pending.
//   Receiver stall: words hold in the buffer; bytes keep flowing until the
//   next last byte, which then holds the input channel until the buffer frees.
module char_class_bitmap_builder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  spec_byte,
    input  logic        spec_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  word_index,
    output logic [63:0] class_word,
    output logic        final_word
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    // Class state
    ccb_pkg::ccb_state_t state_reg;
    ccb_pkg::ccb_state_t state_next;

    logic [ccb_pkg::MAP_BITS-1:0] flush_map;
    logic                         can_load;
    logic                         advance;
    logic                         load;

    // Advance the held byte unless it is a last byte and the buffer is full.
    assign advance  = in_valid_reg && (!end_reg || can_load);
    assign load     = advance && end_reg;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            byte_reg <= spec_byte;
            end_reg  <= spec_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ccb_pkg::STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    ccb_step u_step
    (
        .st_cur    (state_reg),
        .spec_byte (byte_reg),
        .spec_end  (end_reg),
        .st_next   (state_next),
        .flush_map (flush_map)
    );

    ccb_word_out u_word_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_map   (flush_map),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_index (word_index),
        .class_word (class_word),
        .final_word (final_word)
    );

`ifndef ASSERT_OFF
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && end_reg && out_valid))
        else $error("input stalled without a last byte waiting on the buffer");
    a_flush_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid && (word_index == 2'd0)))
        else $error("flushed map not offered from word 0");
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (state_reg.at_start && !state_reg.negate_flag && !state_reg.dash_pending))
        else $error("class state not cleared after last byte");
`endif

endmodule

/* hdl/ccb_step.sv */
// Per-byte update of the class state: escape decode, ranges, negation, flush.
// Depends on ccb_pkg.
module ccb_step
(
    input  ccb_pkg::ccb_state_t         st_cur,
    input  logic [7:0]                  spec_byte,
    input  logic                        spec_end,
    output ccb_pkg::ccb_state_t         st_next,
    output logic [ccb_pkg::MAP_BITS-1:0] flush_map
);

    ccb_pkg::ccb_state_t s;

    always_comb
    begin
        s = st_cur;
        case (st_cur.escape_phase)
            ccb_pkg::PH_ESC:
            begin
                s.escape_phase = ccb_pkg::PH_IDLE;
                if (ccb_pkg::is_octal(spec_byte)) begin
                    s.escape_value = {6'd0, spec_byte[2:0]};
                    s.escape_phase = ccb_pkg::PH_OCT1;
                end
                else if (spec_byte == ccb_pkg::CODE_X) begin
                    s.escape_value = 9'd0;
                    s.escape_phase = ccb_pkg::PH_HEX0;
                end
                else
                    s = ccb_pkg::deliver(s, ccb_pkg::named_code(spec_byte));
            end
            ccb_pkg::PH_OCT1, ccb_pkg::PH_OCT2:
            begin
                if (ccb_pkg::is_octal(spec_byte)) begin
                    s.escape_value = {st_cur.escape_value[5:0], spec_byte[2:0]};
                    if (st_cur.escape_phase == ccb_pkg::PH_OCT1)
                        s.escape_phase = ccb_pkg::PH_OCT2;
                    else begin
                        s.escape_phase = ccb_pkg::PH_IDLE;
                        s = ccb_pkg::deliver(s, s.escape_value[7:0]);
                    end
                end
                else begin
                    s.escape_phase = ccb_pkg::PH_IDLE;
                    s = ccb_pkg::deliver(s, st_cur.escape_value[7:0]);
                    s = ccb_pkg::plain_byte(s, spec_byte, spec_end);
                end
            end
            ccb_pkg::PH_HEX0:
            begin
                if (ccb_pkg::is_hex(spec_byte)) begin
                    s.escape_value = {5'd0, ccb_pkg::hex_digit(spec_byte)};
                    s.escape_phase = ccb_pkg::PH_HEX1;
                end
                else begin
                    s.escape_phase = ccb_pkg::PH_IDLE;
                    s = ccb_pkg::deliver(s, 8'd0);
                    s = ccb_pkg::plain_byte(s, spec_byte, spec_end);
                end
            end
            ccb_pkg::PH_HEX1:
            begin
                s.escape_phase = ccb_pkg::PH_IDLE;
                if (ccb_pkg::is_hex(spec_byte))
                    s = ccb_pkg::deliver(s, {st_cur.escape_value[3:0],
                                             ccb_pkg::hex_digit(spec_byte)});
                else begin
                    s = ccb_pkg::deliver(s, st_cur.escape_value[7:0]);
                    s = ccb_pkg::plain_byte(s, spec_byte, spec_end);
                end
            end
            default:
            begin
                s.escape_phase = ccb_pkg::PH_IDLE;
                s = ccb_pkg::plain_byte(s, spec_byte, spec_end);
            end
        endcase

        // Close an escape cut short by the last byte.
        if (spec_end) begin
            case (s.escape_phase)
                ccb_pkg::PH_ESC:  s = ccb_pkg::deliver(s, ccb_pkg::CODE_BSLASH);
                ccb_pkg::PH_OCT1,
                ccb_pkg::PH_OCT2,
                ccb_pkg::PH_HEX1: s = ccb_pkg::deliver(s, s.escape_value[7:0]);
                ccb_pkg::PH_HEX0: s = ccb_pkg::deliver(s, 8'd0);
                default:          s = s;
            endcase
        end

        flush_map = s.negate_flag ? ~s.member_map : s.member_map;
        st_next   = spec_end ? ccb_pkg::STATE_RESET : s;
    end

endmodule

/* hdl/ccb_word_out.sv */
// Result register: holds a finished 256-bit map and sends it as four 64-bit words.
// Depends on ccb_pkg.
module ccb_word_out
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [ccb_pkg::MAP_BITS-1:0] load_map,
    output logic                         can_load,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   word_index,
    output logic [ccb_pkg::WORD_BITS-1:0] class_word,
    output logic                         final_word
);

    logic [ccb_pkg::MAP_BITS-1:0] map_reg;
    logic [1:0]                   cnt_reg;
    logic                         busy_reg;
    logic                         take;
    logic                         last_take;

    assign take      = busy_reg && out_ready;
    assign last_take = take && (cnt_reg == 2'd3);
    assign can_load  = !busy_reg || last_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 2'd0;
        end
        else if (last_take) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (take) begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            map_reg <= load_map;
    end

    assign out_valid  = busy_reg;
    assign word_index = cnt_reg;
    assign class_word = map_reg[{cnt_reg, 6'd0} +: ccb_pkg::WORD_BITS];
    assign final_word = (cnt_reg == 2'd3);

`ifndef ASSERT_OFF
    a_word_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (cnt_reg != 2'd3) && !load) |=> (busy_reg && (cnt_reg == $past(cnt_reg) + 2'd1)))
        else $error("word index did not advance after a taken word");
    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        (last_take && !load) |=> !busy_reg)
        else $error("buffer still busy after the fourth word");
`endif

endmodule
